FILE: rtl/core/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and codes of the record table: modes, status codes, the
// stored record and the command broadcast to the row of table cells.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned PTR_W = 6;

  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_UPDATE  = 3'd1;
  localparam logic [2:0] MODE_REMOVE  = 3'd2;
  localparam logic [2:0] MODE_COMPACT = 3'd3;
  localparam logic [2:0] MODE_LIST    = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] qty;
    logic        [31:0] val;
    logic               deleted;
  } rec_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_SQUEEZE,
    CMD_LOAD
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [PTR_W-1:0]   ptr;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/tte_cell.sv
// ----------------------------------------------------------------------------
// tte_cell
// One slot of the record row. Holds a record, takes the neighbor's record
// on a rotate, opens a gap on a squeeze step, or loads a new record.
// ----------------------------------------------------------------------------
module tte_cell import tte_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       left_i,
  input  rec_t       right_i,
  input  rec_t       load_i,
  output rec_t       rec_o
);

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.cmd)
      CMD_HOLD:  rec_d = rec_q;
      CMD_LEFT:  rec_d = right_i;
      CMD_RIGHT: rec_d = left_i;
      CMD_SQUEEZE: begin
        if (PTR_W'(IDX) > ctrl_i.ptr) begin
          rec_d = left_i;
        end else if (PTR_W'(IDX) == ctrl_i.ptr) begin
          rec_d.deleted = 1'b1;
        end
      end
      CMD_LOAD: begin
        if (PTR_W'(IDX) == ctrl_i.ptr) begin
          rec_d = load_i;
        end
      end
      default:   rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

FILE: rtl/core/tombstone_table_engine.sv
// ----------------------------------------------------------------------------
// tombstone_table_engine
// Keyed record table kept in a ring of cells, with tombstone removal,
// order-keeping compaction and in-order listing of live records.
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid_i in_ready_o mode_i key_i quantity_i  | input
//           | unit_value_bits_i                             |
//   out     | out_valid_o out_ready_i status_o out_key_o     | output
//           | out_quantity_o out_value_bits_o last_o        |
//
// Append, an empty list and unused modes are handled in idle. Update, remove,
// compact and list rotate the ring of TABLE_DEPTH cells one cell per cycle
// unless a stalled output holds them, and return to idle after a full turn.
// A stalled output transfer freezes the ring in place until the slot frees.
// Reset clears the record counts and control state, not the cells; no clearing pass is needed.
// One item is taken at a time; the next one is taken back in idle.
// ----------------------------------------------------------------------------
module tombstone_table_engine import tte_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] quantity_i,
  input  logic [31:0]        unit_value_bits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_key_o,
  output logic signed [31:0] out_quantity_o,
  output logic [31:0]        out_value_bits_o,
  output logic               last_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PACK = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] qty_q, qty_d;
  logic [31:0]        val_q, val_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [CNT_W-1:0]   emit_q, emit_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q, status_d;
  rec_t               out_rec_q, out_rec_d;
  logic               last_q, last_d;

  rec_t               cells [TABLE_DEPTH];
  rec_t               head_mod;
  rec_t               load_rec;
  cell_ctrl_t         ctrl;

  logic               slot_free;
  logic               last_step;
  logic               scan_live;
  logic               pack_live;
  logic               hit;
  logic               go;
  logic [IDX_W-1:0]   pack_orig;
  logic [CNT_W-1:0]   emit_inc;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_step = (step_q == LAST_STEP);
  assign pack_orig = LAST_STEP - step_q;
  assign emit_inc  = emit_q + CNT_W'(1);
  assign scan_live = (CNT_W'(step_q) < count_q) && !cells[0].deleted;
  assign pack_live = (CNT_W'(pack_orig) < count_q) && !cells[TABLE_DEPTH-1].deleted;
  assign hit       = (op_q != MODE_LIST) && scan_live && !found_q
                     && (cells[0].key == key_q);
  assign load_rec  = '{key: key_i, qty: quantity_i, val: unit_value_bits_i, deleted: 1'b0};
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;

  always_comb begin
    head_mod = cells[0];
    if (hit) begin
      if (op_q == MODE_UPDATE) begin
        head_mod.qty = qty_q;
        head_mod.val = val_q;
      end else begin
        head_mod.deleted = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    qty_d       = qty_q;
    val_d       = val_q;
    found_d     = found_q;
    step_d      = step_q;
    k_d         = k_q;
    count_d     = count_q;
    live_d      = live_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_rec_d   = out_rec_q;
    last_d      = last_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.ptr    = PTR_W'(k_q);
    go          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d    = mode_i;
          key_d   = key_i;
          qty_d   = quantity_i;
          val_d   = unit_value_bits_i;
          found_d = 1'b0;
          step_d  = '0;
          k_d     = '0;
          emit_d  = '0;
          case (mode_i)
            MODE_APPEND: begin
              out_valid_d = 1'b1;
              out_rec_d   = '0;
              last_d      = 1'b1;
              if (count_q < DEPTH_CNT) begin
                ctrl.cmd = CMD_LOAD;
                ctrl.ptr = PTR_W'(count_q);
                count_d  = count_q + CNT_W'(1);
                live_d   = live_q + CNT_W'(1);
                status_d = STATUS_OK;
              end else begin
                status_d = STATUS_FULL;
              end
            end
            MODE_UPDATE, MODE_REMOVE: state_d = ST_SCAN;
            MODE_COMPACT:             state_d = ST_PACK;
            MODE_LIST: begin
              if (live_q == '0) begin
                out_valid_d = 1'b1;
                out_rec_d   = '0;
                last_d      = 1'b1;
                status_d    = STATUS_EMPTY;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (op_q == MODE_LIST) begin
          go = !scan_live || slot_free;
          if (go && scan_live) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_OK;
            out_rec_d   = cells[0];
            last_d      = (emit_inc == live_q);
            emit_d      = emit_inc;
          end
        end else begin
          go = !last_step || slot_free;
          if (go && hit) begin
            found_d = 1'b1;
            if (op_q == MODE_REMOVE) begin
              live_d = live_q - CNT_W'(1);
            end
          end
          if (go && last_step) begin
            out_valid_d = 1'b1;
            out_rec_d   = '0;
            last_d      = 1'b1;
            status_d    = (found_q || hit) ? STATUS_OK : STATUS_NOT_FOUND;
          end
        end
        if (go) begin
          ctrl.cmd = CMD_LEFT;
          step_d   = step_q + IDX_W'(1);
          if (last_step) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PACK: begin
        go = !last_step || slot_free;
        if (go) begin
          ctrl.cmd = pack_live ? CMD_RIGHT : CMD_SQUEEZE;
          ctrl.ptr = PTR_W'(k_q);
          step_d   = step_q + IDX_W'(1);
          if (pack_live) begin
            k_d = k_q + IDX_W'(1);
          end
          if (last_step) begin
            count_d     = live_q;
            out_valid_d = 1'b1;
            out_rec_d   = '0;
            last_d      = 1'b1;
            status_d    = STATUS_OK;
            state_d     = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t left_rec, right_rec;
    if (i == 0) begin : g_first
      assign left_rec = cells[TABLE_DEPTH-1];
    end else begin : g_mid_l
      assign left_rec = cells[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_rec = head_mod;
    end else begin : g_mid_r
      assign right_rec = cells[i+1];
    end
    tte_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_rec),
      .right_i (right_rec),
      .load_i  (load_rec),
      .rec_o   (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      found_q     <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
      count_q     <= '0;
      live_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      step_q      <= step_d;
      k_q         <= k_d;
      count_q     <= count_d;
      live_q      <= live_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    qty_q     <= qty_d;
    val_q     <= val_d;
    status_q  <= status_d;
    out_rec_q <= out_rec_d;
    last_q    <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_key_o        = out_rec_q.key;
  assign out_quantity_o   = out_rec_q.qty;
  assign out_value_bits_o = out_rec_q.val;
  assign last_o           = last_q;

endmodule

FILE: rtl/core/tte_checker.sv
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the record table: output hold under stall, input
// gating on a busy output slot, and the shape of error results.
// ----------------------------------------------------------------------------
module tte_checker import tte_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] out_key_o,
  input logic signed [31:0] out_quantity_o,
  input logic [31:0]        out_value_bits_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_key_o) && $stable(last_o))
    else $error("output changed while stalled");

  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken while output slot busy");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> last_o)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> out_key_o == '0
      && out_quantity_o == '0 && out_value_bits_o == '0)
    else $error("error result carries data");

endmodule

bind tombstone_table_engine tte_checker u_tte_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .out_key_o        (out_key_o),
  .out_quantity_o   (out_quantity_o),
  .out_value_bits_o (out_value_bits_o),
  .last_o           (last_o)
);

FILE: test/tombstone_table_engine_tb.sv
// ----------------------------------------------------------------------------
// tombstone_table_engine_tb
// Self-checking bench for the record table. A directed table walks the
// corner cases (empty list, missing keys, extreme fields, duplicate keys,
// tombstones, unused modes). Random append, update/remove, compact, list and
// fill-to-full sequences follow. Every output transfer is checked against a
// behavioral copy of the table or the planned status, with random bursts on
// the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tombstone_table_engine_tb;
  import tte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned N_ITEMS     = 460;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned N_PLAN      = 26;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key;
    logic signed [31:0] qty;
    logic [31:0]        val;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] qty;
    logic [31:0] val;
    logic        typed;
    logic [1:0]  status;
  } plan_row_t;

  localparam plan_row_t PLAN [N_PLAN] = '{
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b1, STATUS_EMPTY},
    '{MODE_UPDATE,   32'h5,        32'h1,        32'h1,        1'b1, STATUS_NOT_FOUND},
    '{MODE_REMOVE,   32'h5,        32'h0,        32'h0,        1'b1, STATUS_NOT_FOUND},
    '{MODE_COMPACT,  32'h0,        32'h0,        32'h0,        1'b1, STATUS_OK},
    '{MODE_APPEND,   32'h80000000, 32'h80000000, 32'h00000000, 1'b1, STATUS_OK},
    '{MODE_APPEND,   32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1'b1, STATUS_OK},
    '{MODE_APPEND,   32'h0,        32'h0,        32'h0,        1'b1, STATUS_OK},
    '{MODE_APPEND,   32'hffffffff, 32'hffffffff, 32'ha5a5a5a5, 1'b1, STATUS_OK},
    '{MODE_APPEND,   32'h7fffffff, 32'h1,        32'h5a5a5a5a, 1'b1, STATUS_OK},
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_UPDATE,   32'h7fffffff, 32'hfffffffe, 32'h12345678, 1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'h7fffffff, 32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_UPDATE,   32'h7fffffff, 32'h3,        32'hdeadbeef, 1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'h0,        32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'h0,        32'h0,        32'h0,        1'b1, STATUS_NOT_FOUND},
    '{MODE_SPARE_LO, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, STATUS_OK},
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_COMPACT,  32'h0,        32'h0,        32'h0,        1'b1, STATUS_OK},
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_SPARE_HI, 32'h7fffffff, 32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'hffffffff, 32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'h80000000, 32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_REMOVE,   32'h7fffffff, 32'h0,        32'h0,        1'b0, STATUS_OK},
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b1, STATUS_EMPTY},
    '{MODE_COMPACT,  32'h0,        32'h0,        32'h0,        1'b1, STATUS_OK},
    '{MODE_LIST,     32'h0,        32'h0,        32'h0,        1'b1, STATUS_EMPTY}
  };

  logic               clk_i    = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         mode_in  = MODE_APPEND;
  logic signed [31:0] key_in   = '0;
  logic signed [31:0] qty_in   = '0;
  logic [31:0]        val_in   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] out_key;
  logic signed [31:0] out_qty;
  logic [31:0]        out_val;
  logic               out_last;

  rec_t        tbl [DEPTH];
  int unsigned tbl_count = 0;
  result_t     step_out [$];
  result_t     pending_results [$];
  logic [31:0] key_pool [12];
  logic [15:0] stall_pat = 16'hffff;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;

  tombstone_table_engine #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (mode_in),
    .key_i            (key_in),
    .quantity_i       (qty_in),
    .unit_value_bits_i(val_in),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .out_key_o        (out_key),
    .out_quantity_o   (out_qty),
    .out_value_bits_o (out_val),
    .last_o           (out_last)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_status(input logic [1:0] st);
    step_out.push_back(result_t'{st, 32'sd0, 32'sd0, 32'd0, 1'b1});
  endfunction

  function automatic void table_apply(input logic [2:0] mode, input logic [31:0] key,
                                      input logic [31:0] qty, input logic [31:0] val);
    int hit;
    int unsigned live;
    int unsigned w;
    int unsigned k;
    hit = -1;
    live = 0;
    w = 0;
    k = 0;
    step_out.delete();
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (!tbl[i].deleted) begin
        live++;
        if (hit < 0 && tbl[i].key == key) hit = i;
      end
    end
    case (mode)
      MODE_APPEND: begin
        if (tbl_count >= DEPTH) begin
          push_status(STATUS_FULL);
        end else begin
          tbl[tbl_count] = '{key, qty, val, 1'b0};
          tbl_count++;
          push_status(STATUS_OK);
        end
      end
      MODE_UPDATE, MODE_REMOVE: begin
        if (hit < 0) begin
          push_status(STATUS_NOT_FOUND);
        end else begin
          if (mode == MODE_UPDATE) begin
            tbl[hit].qty = qty;
            tbl[hit].val = val;
          end else begin
            tbl[hit].deleted = 1'b1;
          end
          push_status(STATUS_OK);
        end
      end
      MODE_COMPACT: begin
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (!tbl[i].deleted) begin
            tbl[w] = tbl[i];
            w++;
          end
        end
        tbl_count = w;
        push_status(STATUS_OK);
      end
      MODE_LIST: begin
        if (live == 0) begin
          push_status(STATUS_EMPTY);
        end else begin
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (!tbl[i].deleted) begin
              k++;
              step_out.push_back(result_t'{STATUS_OK, tbl[i].key, tbl[i].qty, tbl[i].val,
                                           k == live});
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Drive one item, hold it until the transfer, then predict, and idle between bursts.
  task automatic send_item(input logic [2:0] mode, input logic [31:0] key,
                           input logic [31:0] qty, input logic [31:0] val,
                           input logic typed, input logic [1:0] typed_status);
    in_valid <= 1'b1;
    mode_in  <= mode;
    key_in   <= key;
    qty_in   <= qty;
    val_in   <= val;
    do @(posedge clk_i); while (!in_ready);
    table_apply(mode, key, qty, val);
    if (typed) begin
      pending_results.push_back(result_t'{typed_status, 32'sd0, 32'sd0, 32'd0, 1'b1});
    end else begin
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    end
    if (mode <= MODE_LIST) items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    out_ready <= stall_pat[0];
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status, out_key, out_qty, out_val, out_last};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer status=%0d key=%h qty=%h val=%h last=%b",
                                  got.status, got.key, got.qty, got.val, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.key !== want.key || got.qty !== want.qty ||
            got.val !== want.val || got.last !== want.last) begin
          report_mismatch($sformatf(
            "got st=%0d k=%h q=%h v=%h l=%b, want st=%0d k=%h q=%h v=%h l=%b",
            got.status, got.key, got.qty, got.val, got.last,
            want.status, want.key, want.qty, want.val, want.last));
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    bit filled;
    filled = 1'b0;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffffffff;
    key_pool[2] = 32'h80000000;
    key_pool[3] = 32'h7fffffff;
    key_pool[4] = 32'h1;
    for (int i = 5; i < 12; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_PLAN; i++) begin
      send_item(PLAN[i].mode, PLAN[i].key, PLAN[i].qty, PLAN[i].val,
                PLAN[i].typed, PLAN[i].status);
    end
    items_sent = 0;

    while (items_sent < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (!filled && items_sent > 180) kind = 99;
      if (kind < 30) begin
        n = $urandom_range(1, 12);
        repeat (n) send_item(MODE_APPEND, pick_key(), $urandom, $urandom, 1'b0, STATUS_OK);
      end else if (kind < 55) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item($urandom_range(0, 1) ? MODE_UPDATE : MODE_REMOVE, pick_key(),
                    $urandom, $urandom, 1'b0, STATUS_OK);
        end
      end else if (kind < 65) begin
        send_item(MODE_COMPACT, $urandom, $urandom, $urandom, 1'b0, STATUS_OK);
      end else if (kind < 80) begin
        send_item(MODE_LIST, $urandom, $urandom, $urandom, 1'b0, STATUS_OK);
      end else if (kind < 90) begin
        n = $urandom_range(2, 10);
        repeat (n) send_item(MODE_REMOVE, pick_key(), $urandom, $urandom, 1'b0, STATUS_OK);
        send_item(MODE_COMPACT, $urandom, $urandom, $urandom, 1'b0, STATUS_OK);
      end else if (kind < 96) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_item(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, 1'b0, STATUS_OK);
        end
      end else begin
        while (tbl_count < DEPTH) begin
          send_item(MODE_APPEND, pick_key(), $urandom, $urandom, 1'b0, STATUS_OK);
        end
        n = $urandom_range(1, 3);
        repeat (n) send_item(MODE_APPEND, pick_key(), $urandom, $urandom, 1'b0, STATUS_OK);
        send_item(MODE_LIST, $urandom, $urandom, $urandom, 1'b0, STATUS_OK);
        filled = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tte_pkg.sv
rtl/core/tte_cell.sv
rtl/core/tombstone_table_engine.sv
rtl/core/tte_checker.sv
test/tombstone_table_engine_tb.sv
